// ===== src/tofm_pkg.sv =====
// Package for the timestamp-ordered frame merger: field widths, request and
// status codes, result record. No dependencies.
package tofm_pkg;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned STN_W  = 3;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 3;

  // request codes
  localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_STORED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LATE    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RELEASE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd5;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [STN_W-1:0]  out_station;
    logic [TIME_W-1:0] out_time;
    logic [TAG_W-1:0]  out_tag;
    logic              evicted;
    logic [TAG_W-1:0]  evicted_tag;
    logic [TIME_W-1:0] evicted_time;
  } res_t;

endpackage

// ===== src/tofm_if.sv =====
// Request and result channel interfaces (valid/ready plus payload).
// Depends on tofm_pkg.
interface tofm_in_if import tofm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [STN_W-1:0]  station;
  logic [TIME_W-1:0] frame_time;
  logic [TAG_W-1:0]  frame_tag;

  modport source (output valid, mode, station, frame_time, frame_tag, input ready);
  modport sink   (input valid, mode, station, frame_time, frame_tag, output ready);
endinterface

interface tofm_out_if import tofm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [STN_W-1:0]  out_station;
  logic [TIME_W-1:0] out_time;
  logic [TAG_W-1:0]  out_tag;
  logic              evicted;
  logic [TAG_W-1:0]  evicted_tag;
  logic [TIME_W-1:0] evicted_time;

  modport source (output valid, status, out_station, out_time, out_tag, evicted,
                  evicted_tag, evicted_time, input ready);
  modport sink   (input valid, status, out_station, out_time, out_tag, evicted,
                  evicted_tag, evicted_time, output ready);
endinterface

// ===== src/timestamp_ordered_frame_merger.sv =====
// Timestamp-ordered frame merger: per-station sorted ring buffers in one RAM,
// walked by a small sequencer. Depends on tofm_pkg, tofm_if, tofm_ram.
//
//  channel | dir | payload                                         | transfer
//  in_i    | in  | mode, station, frame_time, frame_tag            | valid & ready
//  out_o   | out | status, out_station, out_time, out_tag,         | valid & ready
//          |     | evicted, evicted_tag, evicted_time              |
//
// One request at a time; in_i.ready is high only while the sequencer idles.
// Store: the insertion walk reads each visited entry from RAM, then compares it
//   and either shifts it one slot up or writes the new entry. An equal timestamp
//   found below shifted entries pulls them back down, one RAM read and one write
//   per shifted entry.
// Pop: skips empty stations, reads the head of each non-empty station, purges
//   stale heads and ranks the rest.
// Link-lost / stop: clear station state. All walks share the single RAM read port.
// Reset clears fill counts and last released times; RAM contents need none.
// A finished result waits in an output register; a new request may be taken
//   meanwhile, and the next result waits until that register frees up.
module timestamp_ordered_frame_merger import tofm_pkg::*; #(
  parameter int unsigned STATIONS = 8,
  parameter int unsigned CAPACITY = 2048,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tofm_in_if.sink     in_i,
  tofm_out_if.source  out_o
);
  localparam int unsigned SW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1);       // ring pointer / count
  localparam int unsigned AW = $clog2(STATIONS << PW);
  localparam int unsigned DW = TIME_W + TAG_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SRD   = 12'b0000_0000_0010,  // store walk: read entry k
    S_SCHK  = 12'b0000_0000_0100,  // store walk: compare and shift
    S_SINS  = 12'b0000_0000_1000,  // insert at buffer head
    S_SFIN  = 12'b0000_0001_0000,  // count update, overflow check
    S_EVCHK = 12'b0000_0010_0000,  // report evicted head
    S_PRD   = 12'b0000_0100_0000,  // pop scan: read station head
    S_PCHK  = 12'b0000_1000_0000,  // purge or rank head
    S_REL   = 12'b0001_0000_0000,  // release winner
    S_DONE  = 12'b0010_0000_0000,  // hand result to output register
    S_URD   = 12'b0100_0000_0000,  // equal time: read shifted entry k+1
    S_UCHK  = 12'b1000_0000_0000   // equal time: move it back to slot k
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0]     head_q [STATIONS];
  logic [PW-1:0]     head_d [STATIONS];
  logic [PW-1:0]     cnt_q  [STATIONS];
  logic [PW-1:0]     cnt_d  [STATIONS];
  logic [TIME_W-1:0] lr_q   [STATIONS];
  logic [TIME_W-1:0] lr_d   [STATIONS];

  logic [SW-1:0]       st_q, st_d;
  logic [TIME_W-1:0]   t_q, t_d;
  logic [TAG_BITS-1:0] g_q, g_d;
  logic [PW-1:0]       k_q, k_d;
  logic                eq_q, eq_d;
  logic                found_q, found_d;
  logic [SW-1:0]       best_q, best_d;
  logic [TIME_W-1:0]   best_t_q, best_t_d;
  logic [TAG_BITS-1:0] best_g_q, best_g_d;
  res_t                rs_q, rs_d;
  res_t                out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  // RAM time field and ring head of the station in work
  logic [TIME_W-1:0] e_time;
  logic [PW-1:0]     h;
  logic [PW-1:0]     n;
  logic [SW-1:0]     s_in;
  logic              s_in_ok;

  assign e_time  = rdata[DW-1:TAG_BITS];
  assign h       = head_q[st_q];
  assign n       = cnt_q[st_q];
  assign s_in    = SW'(in_i.station);
  assign s_in_ok = (32'(in_i.station) < STATIONS);

  function automatic logic [AW-1:0] ring_addr(logic [SW-1:0] s, logic [PW-1:0] p);
    return AW'({s, p});
  endfunction

  tofm_ram #(.WIDTH(DW), .DEPTH(STATIONS << PW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    lr_d     = lr_q;
    st_d     = st_q;
    t_d      = t_q;
    g_d      = g_q;
    k_d      = k_q;
    eq_d     = eq_q;
    found_d  = found_q;
    best_d   = best_q;
    best_t_d = best_t_q;
    best_g_d = best_g_q;
    rs_d     = rs_q;
    out_d    = out_q;
    out_vld_d = out_vld_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          st_d = s_in;
          t_d  = in_i.frame_time;
          g_d  = TAG_BITS'(in_i.frame_tag);
          rs_d = '0;
          eq_d = 1'b0;
          unique case (in_i.mode)
            MODE_STORE: begin
              if (in_i.frame_time == '0 || !s_in_ok) begin
                rs_d.status = STAT_DROPPED;
                state_d     = S_DONE;
              end else if (cnt_q[s_in] == '0) begin
                we      = 1'b1;
                waddr   = ring_addr(s_in, head_q[s_in]);
                wdata   = {in_i.frame_time, TAG_BITS'(in_i.frame_tag)};
                state_d = S_SFIN;
              end else begin
                k_d     = cnt_q[s_in] - 1'b1;
                state_d = S_SRD;
              end
            end
            MODE_POP: begin
              st_d    = '0;
              found_d = 1'b0;
              state_d = S_PRD;
            end
            MODE_LINK: begin
              if (s_in_ok) begin
                cnt_d[s_in] = '0;
                lr_d[s_in]  = '0;
              end
              rs_d.status = STAT_CLEARED;
              state_d     = S_DONE;
            end
            MODE_STOP: begin
              for (int s = 0; s < STATIONS; s++) begin
                if (cnt_q[s] != '0) begin
                  cnt_d[s] = '0;
                  lr_d[s]  = '0;
                end
              end
              rs_d.status = STAT_CLEARED;
              state_d     = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SRD: begin
        raddr   = ring_addr(st_q, h + k_q);
        state_d = S_SCHK;
      end

      S_SCHK: begin
        we = 1'b1;
        if (e_time > t_q) begin
          // shift this entry one slot toward the tail
          waddr = ring_addr(st_q, h + k_q + 1'b1);
          wdata = rdata;
          if (k_q == '0) begin
            state_d = S_SINS;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = S_SRD;
          end
        end else if (e_time == t_q) begin
          waddr   = ring_addr(st_q, h + k_q);
          wdata   = {t_q, g_q};
          eq_d    = 1'b1;
          if (k_q == n - 1'b1) begin
            state_d = S_SFIN;
          end else begin
            // entries above k already moved up one slot; pull them back
            k_d     = k_q + 1'b1;
            state_d = S_URD;
          end
        end else begin
          waddr   = ring_addr(st_q, h + k_q + 1'b1);
          wdata   = {t_q, g_q};
          state_d = S_SFIN;
        end
      end

      S_URD: begin
        raddr   = ring_addr(st_q, h + k_q + 1'b1);
        state_d = S_UCHK;
      end

      S_UCHK: begin
        we    = 1'b1;
        waddr = ring_addr(st_q, h + k_q);
        wdata = rdata;
        if (k_q == n - 1'b1) begin
          state_d = S_SFIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_URD;
        end
      end

      S_SINS: begin
        we      = 1'b1;
        waddr   = ring_addr(st_q, h);
        wdata   = {t_q, g_q};
        state_d = S_SFIN;
      end

      S_SFIN: begin
        rs_d.status = ((t_q <= lr_q[st_q]) || eq_q) ? STAT_LATE : STAT_STORED;
        if (eq_q) begin
          state_d = S_DONE;
        end else if (n == PW'(CAPACITY)) begin
          // full buffer went one over: oldest entry leaves, count stays
          raddr   = ring_addr(st_q, h);
          state_d = S_EVCHK;
        end else begin
          cnt_d[st_q] = n + 1'b1;
          state_d     = S_DONE;
        end
      end

      S_EVCHK: begin
        rs_d.evicted      = 1'b1;
        rs_d.evicted_time = e_time;
        rs_d.evicted_tag  = TAG_W'(rdata[TAG_BITS-1:0]);
        head_d[st_q]      = h + 1'b1;
        state_d           = S_DONE;
      end

      S_PRD: begin
        if (n == '0) begin
          if (st_q == SW'(STATIONS - 1)) begin
            state_d = S_REL;
          end else begin
            st_d = st_q + 1'b1;
          end
        end else begin
          raddr   = ring_addr(st_q, h);
          state_d = S_PCHK;
        end
      end

      S_PCHK: begin
        if (e_time <= lr_q[st_q]) begin
          // stale head: purge and look again
          head_d[st_q] = h + 1'b1;
          cnt_d[st_q]  = n - 1'b1;
          state_d      = S_PRD;
        end else begin
          if (!found_q || e_time < best_t_q) begin
            found_d  = 1'b1;
            best_d   = st_q;
            best_t_d = e_time;
            best_g_d = rdata[TAG_BITS-1:0];
          end
          if (st_q == SW'(STATIONS - 1)) begin
            state_d = S_REL;
          end else begin
            st_d    = st_q + 1'b1;
            state_d = S_PRD;
          end
        end
      end

      S_REL: begin
        if (found_q) begin
          rs_d.status      = STAT_RELEASE;
          rs_d.out_station = STN_W'(best_q);
          rs_d.out_time    = best_t_q;
          rs_d.out_tag     = TAG_W'(best_g_q);
          lr_d[best_q]     = best_t_q;
          head_d[best_q]   = head_q[best_q] + 1'b1;
          cnt_d[best_q]    = cnt_q[best_q] - 1'b1;
        end else begin
          rs_d.status = STAT_NONE;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = rs_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int s = 0; s < STATIONS; s++) begin
        cnt_q[s]  <= '0;
        lr_q[s]   <= '0;
        head_q[s] <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      lr_q      <= lr_d;
      head_q    <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q     <= st_d;
    t_q      <= t_d;
    g_q      <= g_d;
    k_q      <= k_d;
    eq_q     <= eq_d;
    found_q  <= found_d;
    best_q   <= best_d;
    best_t_q <= best_t_d;
    best_g_q <= best_g_d;
    rs_q     <= rs_d;
    out_q    <= out_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_q.status;
  assign out_o.out_station  = out_q.out_station;
  assign out_o.out_time     = out_q.out_time;
  assign out_o.out_tag      = out_q.out_tag;
  assign out_o.evicted      = out_q.evicted;
  assign out_o.evicted_tag  = out_q.evicted_tag;
  assign out_o.evicted_time = out_q.evicted_time;

endmodule

// ===== src/tofm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tofm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/tofm_checker.sv =====
// Port-level checker for the frame merger, bound to the top level.
// Depends on tofm_pkg.
module tofm_checker import tofm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic [STN_W-1:0]  out_station_i,
  input logic [TIME_W-1:0] out_time_i,
  input logic [TAG_W-1:0]  out_tag_i,
  input logic              evicted_i,
  input logic [TAG_W-1:0]  evicted_tag_i,
  input logic [TIME_W-1:0] evicted_time_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(out_time_i))
    else $error("result changed under stall");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= STAT_CLEARED)
    else $error("bad status");

  a_release_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STAT_RELEASE |->
      out_time_i == '0 && out_tag_i == '0 && out_station_i == '0)
    else $error("release fields set without release");

  a_evict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evicted_i |->
      (status_i == STAT_STORED || status_i == STAT_LATE) && evicted_time_i != '0)
    else $error("eviction outside a store");
endmodule

bind timestamp_ordered_frame_merger tofm_checker u_tofm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .out_station_i  (out_o.out_station),
  .out_time_i     (out_o.out_time),
  .out_tag_i      (out_o.out_tag),
  .evicted_i      (out_o.evicted),
  .evicted_tag_i  (out_o.evicted_tag),
  .evicted_time_i (out_o.evicted_time)
);
